FILE: hw/rtl/spm_pkg.sv
`timescale 1ns / 1ps
package spm_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ROW_PIXELS  = 8;
  localparam int PIX_W       = $clog2(ROW_PIXELS);
  localparam int X_W         = 9;

  // Configuration register indexes (byte address 4*index)
  localparam logic [1:0] REG_BG_PALETTE       = 2'd0;
  localparam logic [1:0] REG_OBJ_PALETTE_ZERO = 2'd1;
  localparam logic [1:0] REG_OBJ_PALETTE_ONE  = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_OUTPUT  = 2'd1,
    OP_DISCARD = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  // One queued sprite pixel
  typedef struct packed {
    logic [X_W-1:0] x;
    logic [1:0]     colour;
    logic           pal;
    logic           prio;
  } sprite_px_t;

  // Per-lane overwrite decision: which row pixel replaces this entry
  typedef struct packed {
    logic             ovr;
    logic [PIX_W-1:0] idx;
  } lane_hit_t;

  // Request from the top level to the queue for one transaction
  typedef struct packed {
    op_t        op;
    logic       pop;
    logic [7:0] tile_low;
    logic [7:0] tile_high;
    logic [7:0] sprite_x;
    logic       x_flip;
    logic       sprite_palette;
    logic       behind_background;
  } queue_req_t;

  // Mixer decision for an output transaction
  typedef struct packed {
    logic [1:0] shade;
    logic       from_sprite;
    logic       pop;
  } mix_res_t;

endpackage

FILE: hw/rtl/spm_lane.sv
`timescale 1ns / 1ps
module spm_lane import spm_pkg::*; (
  input  logic                       active,
  input  sprite_px_t                 entry,
  input  logic [7:0]                 sprite_x,
  input  logic                       prio,
  input  logic [ROW_PIXELS-1:0][1:0] pix_colour,
  output lane_hit_t                  hit
);

  logic [X_W-1:0]   diff;
  logic             in_row;
  logic [PIX_W-1:0] idx;
  logic [1:0]       new_colour;
  logic             wins;

  // Locate the row pixel that shares this entry's x
  assign diff   = entry.x - {1'b0, sprite_x};
  assign in_row = active && (diff[X_W-1:PIX_W] == '0);
  assign idx    = diff[PIX_W-1:0];

  // Replace a transparent entry or one of weaker priority with an opaque pixel
  assign new_colour = pix_colour[idx];
  assign wins = (new_colour != 2'd0) && ((entry.colour == 2'd0) || (entry.prio && !prio));

  assign hit.ovr = in_row && wins;
  assign hit.idx = idx;

endmodule

FILE: hw/rtl/spm_queue.sv
`timescale 1ns / 1ps
module spm_queue import spm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  queue_req_t       req,
  output sprite_px_t       front,
  output logic [CNT_W-1:0] count,
  output logic [CNT_W-1:0] count_nxt
);

  sprite_px_t                 entry_r   [QUEUE_DEPTH];
  sprite_px_t                 entry_nxt [QUEUE_DEPTH];
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt_c;
  logic [ROW_PIXELS-1:0][1:0] pix_colour;
  logic [QUEUE_DEPTH-1:0]     lane_act;
  lane_hit_t                  hit [QUEUE_DEPTH];
  logic [ROW_PIXELS-1:0]      taken;
  logic [QUEUE_DEPTH-1:0]     app_vld;
  logic [PIX_W-1:0]           app_src [QUEUE_DEPTH];
  logic [CNT_W-1:0]           app_cnt;
  logic                       do_pop;

  // Decode the tile row into colour numbers, leftmost pixel first
  always_comb begin
    logic [PIX_W-1:0] b;
    b = '0;
    for (int i = 0; i < ROW_PIXELS; i++) begin
      b = req.x_flip ? PIX_W'(i) : PIX_W'(ROW_PIXELS - 1 - i);
      pix_colour[i] = {req.tile_high[b], req.tile_low[b]};
    end
  end

  // One compare lane per queued entry
  for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_lane
    assign lane_act[j] = CNT_W'(j) < count_r;
    spm_lane u_lane (
      .active     (lane_act[j]),
      .entry      (entry_r[j]),
      .sprite_x   (req.sprite_x),
      .prio       (req.behind_background),
      .pix_colour (pix_colour),
      .hit        (hit[j])
    );
  end

  // Merge lane decisions into a per-pixel taken mask
  always_comb begin
    taken = '0;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (hit[j].ovr) begin
        taken[hit[j].idx] = 1'b1;
      end
    end
  end

  // Compact the untaken pixels beyond the old count into the free slots
  always_comb begin
    logic [CNT_W-1:0] dst;
    dst     = '0;
    app_vld = '0;
    app_cnt = '0;
    for (int d = 0; d < QUEUE_DEPTH; d++) begin
      app_src[d] = '0;
    end
    for (int i = 0; i < ROW_PIXELS; i++) begin
      if ((CNT_W'(i) >= count_r) && !taken[i]) begin
        dst = count_r + app_cnt;
        app_vld[dst[IDX_W-1:0]] = 1'b1;
        app_src[dst[IDX_W-1:0]] = PIX_W'(i);
        app_cnt = app_cnt + CNT_W'(1);
      end
    end
  end

  // Next queue contents and count
  always_comb begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      entry_nxt[j] = entry_r[j];
    end
    count_nxt_c = count_r;
    do_pop      = 1'b0;
    case (req.op)
      OP_PUSH: begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
          if (hit[j].ovr) begin
            entry_nxt[j].colour = pix_colour[hit[j].idx];
            entry_nxt[j].pal    = req.sprite_palette;
            entry_nxt[j].prio   = req.behind_background;
          end else if (app_vld[j]) begin
            entry_nxt[j].x      = {1'b0, req.sprite_x} + X_W'(app_src[j]);
            entry_nxt[j].colour = pix_colour[app_src[j]];
            entry_nxt[j].pal    = req.sprite_palette;
            entry_nxt[j].prio   = req.behind_background;
          end
        end
        count_nxt_c = count_r + app_cnt;
      end
      OP_OUTPUT: begin
        do_pop = req.pop && (count_r != '0);
      end
      OP_DISCARD: begin
        do_pop = count_r != '0;
      end
      OP_CLEAR: begin
        count_nxt_c = '0;
      end
      default: begin
        count_nxt_c = count_r;
      end
    endcase
    // Advance every entry one place toward the front
    if (do_pop) begin
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
        entry_nxt[j] = entry_r[j + 1];
      end
      count_nxt_c = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt_c;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
        entry_r[j] <= entry_nxt[j];
      end
    end
  end

  assign front     = entry_r[0];
  assign count     = count_r;
  assign count_nxt = count_nxt_c;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (req.op == OP_CLEAR) |=> count_r == '0)
    else $error("clear left pixels queued");

  a_push_no_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (req.op == OP_PUSH) |=> count_r >= $past(count_r))
    else $error("push reduced queue count");

  a_discard_pops: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (req.op == OP_DISCARD) && (count_r != '0)
    |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("discard did not pop exactly one pixel");
`endif

endmodule

FILE: hw/rtl/spm_mix.sv
`timescale 1ns / 1ps
module spm_mix import spm_pkg::*; (
  input  logic [1:0]       bg_color,
  input  logic             bg_window_enable,
  input  logic             sprites_enable,
  input  sprite_px_t       front,
  input  logic [CNT_W-1:0] count,
  input  logic [7:0]       bg_palette,
  input  logic [7:0]       obj_palette_zero,
  input  logic [7:0]       obj_palette_one,
  output mix_res_t         res
);

  function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] colour);
    shade_of = pal[{colour, 1'b0} +: 2];
  endfunction

  logic [1:0] bg;
  logic       wins;
  logic [7:0] obj_pal;

  // Force background to colour zero when disabled
  assign bg = bg_window_enable ? bg_color : 2'd0;

  // Pop the front pixel whenever sprites are on and one is queued
  assign res.pop = sprites_enable && (count != '0);

  // Sprite wins unless transparent or hidden behind opaque background
  assign wins    = res.pop && (!front.prio || (bg == 2'd0)) && (front.colour != 2'd0);
  assign obj_pal = front.pal ? obj_palette_one : obj_palette_zero;

  assign res.from_sprite = wins;
  assign res.shade       = wins ? shade_of(obj_pal, front.colour) : shade_of(bg_palette, bg);

endmodule

FILE: hw/rtl/sprite_pixel_fifo_mixer.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// in_       slave      in_tvalid/in_tready   tuser: operation; tdata: row and mix fields
// out_      master     out_tvalid/out_tready tuser: shade_valid; tdata: shade, flags, count
// cfg_      APB slave  psel/penable/pready   three 8-bit palettes at 0x0, 0x4, 0x8
//
// The queue updates at the accepting edge and its result sits in the output register
// from the next cycle on. Throughput is one transaction per cycle while in_tready is
// high; the lane compare and append compaction over the eight queue entries are
// combinational.
// in_tready drops only while a result waits and out_tready is low.
// Reset clears the queue count, palettes and output valid; queue entries are
// not cleared.
module sprite_pixel_fifo_mixer import spm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] tile_low, [15:8] tile_high, [23:16] sprite_x, [24] x_flip,
  // [25] sprite_palette, [26] behind_background, [28:27] bg_color,
  // [29] bg_window_enable, [30] sprites_enable, [31] zero
  input  logic [31:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] shade, [2] from_sprite, [6:3] queued_count, [7] zero
  output logic [7:0]  out_tdata,
  // [0] shade_valid
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic             in_accept;
  logic             cfg_write;
  logic [1:0]       cfg_index;
  op_t              op;
  queue_req_t       qreq;
  mix_res_t         mix;
  sprite_px_t       front;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_nxt;

  logic [7:0]       bg_palette_r;
  logic [7:0]       obj_palette_zero_r;
  logic [7:0]       obj_palette_one_r;

  logic             out_valid_r;
  logic [1:0]       out_shade_r;
  logic             out_from_r;
  logic             out_svalid_r;
  logic [CNT_W-1:0] out_count_r;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_index  = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_palette_r       <= '0;
      obj_palette_zero_r <= '0;
      obj_palette_one_r  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BG_PALETTE:       bg_palette_r       <= cfg_pwdata[7:0];
        REG_OBJ_PALETTE_ZERO: obj_palette_zero_r <= cfg_pwdata[7:0];
        REG_OBJ_PALETTE_ONE:  obj_palette_one_r  <= cfg_pwdata[7:0];
        default: begin
          bg_palette_r <= bg_palette_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_BG_PALETTE:       cfg_prdata = {24'd0, bg_palette_r};
      REG_OBJ_PALETTE_ZERO: cfg_prdata = {24'd0, obj_palette_zero_r};
      REG_OBJ_PALETTE_ONE:  cfg_prdata = {24'd0, obj_palette_one_r};
      default:              cfg_prdata = '0;
    endcase
  end

  // Input handshake: the output register frees as its transaction leaves
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);

  spm_mix u_mix (
    .bg_color         (in_tdata[28:27]),
    .bg_window_enable (in_tdata[29]),
    .sprites_enable   (in_tdata[30]),
    .front            (front),
    .count            (count),
    .bg_palette       (bg_palette_r),
    .obj_palette_zero (obj_palette_zero_r),
    .obj_palette_one  (obj_palette_one_r),
    .res              (mix)
  );

  assign qreq.op                = op;
  assign qreq.pop               = mix.pop;
  assign qreq.tile_low          = in_tdata[7:0];
  assign qreq.tile_high         = in_tdata[15:8];
  assign qreq.sprite_x          = in_tdata[23:16];
  assign qreq.x_flip            = in_tdata[24];
  assign qreq.sprite_palette    = in_tdata[25];
  assign qreq.behind_background = in_tdata[26];

  spm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .req       (qreq),
    .front     (front),
    .count     (count),
    .count_nxt (count_nxt)
  );

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_svalid_r <= (op == OP_OUTPUT);
      out_shade_r  <= (op == OP_OUTPUT) ? mix.shade : 2'd0;
      out_from_r   <= (op == OP_OUTPUT) && mix.from_sprite;
      out_count_r  <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_from_r, out_shade_r};
  assign out_tuser  = out_svalid_r;

endmodule
